>>> design/olte_pkg.sv
// Shared constants, operation codes and control types of the ordered list table engine.
package olte_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PRIOR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd5;

  // pointer load selects
  localparam logic [1:0] LD_NONE = 2'd0;
  localparam logic [1:0] LD_CNT  = 2'd1;
  localparam logic [1:0] LD_POS  = 2'd2;
  localparam logic [1:0] LD_ZERO = 2'd3;

  typedef struct packed {
    logic       take;
    logic [1:0] ld;
    logic       rinc;
    logic       rdec;
    logic       winc;
    logic       wdec;
    logic       we;
    logic       wr_val;
    logic       prev_ld;
    logic       clr_res;
    logic       cap_rdata;
    logic       cap_prev;
    logic       set_found;
    logic       set_ok;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pos_ok;
    logic              ins_ok;
    logic              pos_at_end;
    logic              cnt_zero;
    logic              w_eq_pos;
    logic              w1_eq_cnt;
    logic              w2_eq_cnt;
    logic              hit;
    logic              w_zero;
    logic              out_free;
  } stat_t;

endpackage

>>> design/olte_if.sv
// Valid/ready channel interfaces for operation requests and results.
interface olte_req_if;
  import olte_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;
  modport source (output valid, kind, position, value, input ready);
  modport sink (input valid, kind, position, value, output ready);
endinterface

interface olte_rsp_if;
  import olte_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [VALUE_W-1:0] data;
  logic [POS_W-1:0]   found_at;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  modport source (output valid, status, data, found_at, count, is_empty, input ready);
  modport sink (input valid, status, data, found_at, count, is_empty, output ready);
endinterface

>>> design/olte_ctrl.sv
// Operation sequencer: walks insert, delete, read and search through the element RAM.
module olte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  olte_pkg::stat_t stat,
  output olte_pkg::cmd_t  cmd
);
  import olte_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DECIDE    = 4'd1;
  localparam logic [3:0] ST_INS_PRE   = 4'd2;
  localparam logic [3:0] ST_INS_SHIFT = 4'd3;
  localparam logic [3:0] ST_INS_PUT   = 4'd4;
  localparam logic [3:0] ST_RD_PRE    = 4'd5;
  localparam logic [3:0] ST_RD_HEAD   = 4'd6;
  localparam logic [3:0] ST_DEL_SHIFT = 4'd7;
  localparam logic [3:0] ST_SRCH_PRE  = 4'd8;
  localparam logic [3:0] ST_SRCH      = 4'd9;
  localparam logic [3:0] ST_NEXT_GET  = 4'd10;
  localparam logic [3:0] ST_FINISH    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.clr_res = 1'b1;
        state_next  = ST_FINISH;
        unique case (stat.kind) inside
          KIND_INSERT: begin
            if (stat.ins_ok) begin
              cmd.ld     = LD_CNT;
              state_next = stat.pos_at_end ? ST_INS_PUT : ST_INS_PRE;
            end
          end
          KIND_DELETE, KIND_GET: begin
            if (stat.pos_ok) begin
              cmd.ld     = LD_POS;
              state_next = ST_RD_PRE;
            end
          end
          KIND_LOCATE, KIND_PRIOR, KIND_NEXT: begin
            if (!stat.cnt_zero) begin
              cmd.ld     = LD_ZERO;
              state_next = ST_SRCH_PRE;
            end
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_INS_PRE: begin
        cmd.rdec   = 1'b1;
        state_next = ST_INS_SHIFT;
      end
      ST_INS_SHIFT: begin
        cmd.we   = 1'b1;
        cmd.rdec = 1'b1;
        cmd.wdec = 1'b1;
        if (stat.w_eq_pos) begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        cmd.we      = 1'b1;
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.set_ok  = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_RD_PRE: begin
        cmd.rinc   = 1'b1;
        state_next = ST_RD_HEAD;
      end
      ST_RD_HEAD: begin
        cmd.cap_rdata = 1'b1;
        cmd.set_ok    = 1'b1;
        cmd.rinc      = 1'b1;
        if (stat.kind == KIND_GET) begin
          state_next = ST_FINISH;
        end else if (stat.w1_eq_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_next  = ST_FINISH;
        end else begin
          state_next = ST_DEL_SHIFT;
        end
      end
      ST_DEL_SHIFT: begin
        cmd.we   = 1'b1;
        cmd.winc = 1'b1;
        cmd.rinc = 1'b1;
        if (stat.w2_eq_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_next  = ST_FINISH;
        end
      end
      ST_SRCH_PRE: begin
        cmd.rinc   = 1'b1;
        state_next = ST_SRCH;
      end
      ST_SRCH: begin
        if (stat.hit) begin
          state_next = ST_FINISH;
          case (stat.kind)
            KIND_LOCATE: begin
              cmd.set_found = 1'b1;
              cmd.set_ok    = 1'b1;
            end
            KIND_PRIOR: begin
              if (!stat.w_zero) begin
                cmd.cap_prev = 1'b1;
                cmd.set_ok   = 1'b1;
              end
            end
            default: begin
              if (!stat.w1_eq_cnt) begin
                state_next = ST_NEXT_GET;
              end
            end
          endcase
        end else if (stat.w1_eq_cnt) begin
          state_next = ST_FINISH;
        end else begin
          cmd.winc    = 1'b1;
          cmd.rinc    = 1'b1;
          cmd.prev_ld = 1'b1;
        end
      end
      ST_NEXT_GET: begin
        cmd.cap_rdata = 1'b1;
        cmd.set_ok    = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> design/olte_dp.sv
// Datapath: element RAM, pointers, element count, result and output registers.
module olte_dp #(
  parameter int CAPACITY   = olte_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = olte_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  olte_pkg::cmd_t               cmd,
  output olte_pkg::stat_t              stat,
  input  logic [olte_pkg::KIND_W-1:0]  req_kind,
  input  logic [olte_pkg::POS_W-1:0]   req_position,
  input  logic [olte_pkg::VALUE_W-1:0] req_value,
  input  logic                         rsp_ready,
  output logic                         rsp_valid,
  output logic                         rsp_status,
  output logic [olte_pkg::VALUE_W-1:0] rsp_data,
  output logic [olte_pkg::POS_W-1:0]   rsp_found_at,
  output logic [olte_pkg::COUNT_W-1:0] rsp_count,
  output logic                         rsp_is_empty
);
  import olte_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [ELEM_WIDTH-1:0] mem [CAPACITY];
  logic [ELEM_WIDTH-1:0] rdata;
  logic [ELEM_WIDTH-1:0] prev;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [KIND_W-1:0]     kind_r;
  logic [POS_W-1:0]      pos_r;
  logic [AW-1:0]         rptr;
  logic [AW-1:0]         wptr;
  logic [CW-1:0]         count;
  logic                  res_status;
  logic [ELEM_WIDTH-1:0] res_data;
  logic [CW-1:0]         res_found;

  logic [63:0]           val_wide;
  logic [63:0]           res_wide;
  logic [POS_W-1:0]      pos_m1;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         w_x;
  logic [XW-1:0]         found_x;

  assign val_wide = 64'(req_value);
  assign res_wide = 64'(res_data);
  assign pos_m1   = pos_r - 1'b1;
  assign pos_x    = XW'(pos_r);
  assign cnt_x    = XW'(count);
  assign w_x      = XW'(wptr);
  assign found_x  = XW'(res_found);

  always_comb begin
    stat.kind       = kind_r;
    stat.pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
    stat.ins_ok     = (pos_x != '0) && (pos_x <= cnt_x + 1'b1) && (cnt_x < XW'(CAPACITY));
    stat.pos_at_end = (pos_x == cnt_x + 1'b1);
    stat.cnt_zero   = (count == '0);
    stat.w_eq_pos   = (w_x == pos_x);
    stat.w1_eq_cnt  = (w_x + XW'(1) == cnt_x);
    stat.w2_eq_cnt  = (w_x + XW'(2) == cnt_x);
    stat.hit        = (rdata == val_r);
    stat.w_zero     = (wptr == '0);
    stat.out_free   = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r <= req_kind;
      pos_r  <= req_position;
      val_r  <= val_wide[ELEM_WIDTH-1:0];
    end
    case (cmd.ld)
      LD_CNT: begin
        wptr <= AW'(count);
        rptr <= AW'(count) - 1'b1;
      end
      LD_POS: begin
        wptr <= AW'(pos_m1);
        rptr <= AW'(pos_m1);
      end
      LD_ZERO: begin
        wptr <= '0;
        rptr <= '0;
      end
      default: begin
        if (cmd.winc) wptr <= wptr + 1'b1;
        if (cmd.wdec) wptr <= wptr - 1'b1;
        if (cmd.rinc) rptr <= rptr + 1'b1;
        if (cmd.rdec) rptr <= rptr - 1'b1;
      end
    endcase
    if (cmd.prev_ld) prev <= rdata;
    if (cmd.clr_res) begin
      res_status <= 1'b1;
      res_data   <= '0;
      res_found  <= '0;
    end
    if (cmd.cap_rdata) res_data <= rdata;
    if (cmd.cap_prev) res_data <= prev;
    if (cmd.set_found) res_found <= CW'(wptr) + 1'b1;
    if (cmd.set_ok) res_status <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[wptr] <= cmd.wr_val ? val_r : rdata;
    end
    rdata <= mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_status   <= res_status;
      rsp_data     <= res_wide[VALUE_W-1:0];
      rsp_found_at <= found_x[POS_W-1:0];
      rsp_count    <= cnt_x[COUNT_W-1:0];
      rsp_is_empty <= (count == '0);
    end
  end

endmodule

>>> design/ordered_list_table_engine_top.sv
// Top level of the ordered list table engine.
//
//   channel  role    carries
//   req      sink    kind, position, value
//   rsp      source  status, data, found_at, count, is_empty
//
// One element moves or is compared per cycle through the element RAM (one read, one write port).
// Get reads the element at position, delete also shifts the later elements down, insert shifts
// elements up from the end and then writes the value (directly when appending), a search compares
// from the head; an item rejected at decode, or a search of an empty list, goes to the result.
// The next item is taken once the result sits in the output register.
// Synchronous reset empties the list and drops any pending result; RAM is not cleared.
module ordered_list_table_engine_top #(
  parameter int CAPACITY   = olte_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = olte_pkg::ELEM_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  olte_req_if.sink  req,
  olte_rsp_if.source rsp
);
  import olte_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  olte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  olte_dp #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_kind     (req.kind),
    .req_position (req.position),
    .req_value    (req.value),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .rsp_status   (rsp.status),
    .rsp_data     (rsp.data),
    .rsp_found_at (rsp.found_at),
    .rsp_count    (rsp.count),
    .rsp_is_empty (rsp.is_empty)
  );

endmodule

>>> design/olte_checker.sv
// Port-level assertions for the ordered list table engine, bound to the top level.
module olte_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_status,
  input logic [olte_pkg::VALUE_W-1:0] rsp_data,
  input logic [olte_pkg::POS_W-1:0]   rsp_found_at,
  input logic [olte_pkg::COUNT_W-1:0] rsp_count,
  input logic                         rsp_is_empty
);
  import olte_pkg::*;

  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result pending after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_count))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_data == '0 && rsp_found_at == '0)
    else $error("error result carries data");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_found_at <= rsp_count)
    else $error("found position beyond count");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_is_empty == (rsp_count == '0))
    else $error("empty flag disagrees with count");

endmodule

bind ordered_list_table_engine_top olte_checker u_olte_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_data     (rsp.data),
  .rsp_found_at (rsp.found_at),
  .rsp_count    (rsp.count),
  .rsp_is_empty (rsp.is_empty)
);
